// ===== src/ffba_pkg.sv =====
// ffba_pkg: shared constants, codes, table entry type and rounding helper
// used by the first-fit allocator top level
package ffba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int OFF_W        = 23;
    localparam int HEAP_W       = 21;
    localparam int ADDR_BITS    = 20;
    localparam int HEADER_BYTES = 32;
    localparam int ALIGN_BYTES  = 16;
    localparam int SPLIT_MIN    = HEADER_BYTES + 4;
    localparam int HEAP_RESET   = 4096;
    localparam int BLK_W        = 2 * OFF_W + 1;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_RESET = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [CNT_W-1:0] NO_BLOCK = CNT_W'(MAX_BLOCKS);

    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic [OFF_W-1:0] size;
        logic             is_free;
    } t_blk;

    function automatic logic [OFF_W-1:0] round_up(input logic [OFF_W-1:0] x);
        logic [OFF_W-1:0] s;
        s = x + OFF_W'(ALIGN_BYTES - 1);
        return s & ~OFF_W'(ALIGN_BYTES - 1);
    endfunction

endpackage

// ===== src/first_fit_block_allocator.sv =====
// first_fit_block_allocator: first-fit heap allocator over an address-ordered block table
// depends on ffba_pkg and ffba_ram
//
// usage: raise start with i_cmd, i_request_bytes and i_free_address; the command
// transfers at the clock edge where start is high and busy is low. busy stays high
// while the command runs. one result (o_status, o_payload_address) appears for exactly
// one cycle with o_done high; the receiver cannot stall it.
// reset and unused commands finish straight from idle; allocate and free walk the block
// chain with one registered table read (S_WALK) plus the compare (S_CHK) per block, for
// up to 64 blocks, and an allocate then passes through the split or the append states.
// one command at a time; a new command can transfer in the cycle o_done is high.
// heap_bytes is written on the apb port at address 0; the user must do so only while idle, unchecked here.
// after reset the table is empty, heap_bytes is 4096 and the block is idle; the table
// memory needs no clearing since only entries below the block count are read.
module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_cmd,
    input  logic [19:0]          i_request_bytes,
    input  logic [19:0]          i_free_address,
    output logic                 o_done,
    output logic [1:0]           o_status,
    output logic [19:0]          o_payload_address,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_WALK = 14'b00000000000010,
        S_CHK  = 14'b00000000000100,
        S_NXT  = 14'b00000000001000,
        S_NXG  = 14'b00000000010000,
        S_SPA  = 14'b00000000100000,
        S_SPB  = 14'b00000001000000,
        S_SPC  = 14'b00000010000000,
        S_WRN  = 14'b00000100000000,
        S_WRB  = 14'b00001000000000,
        S_APA  = 14'b00010000000000,
        S_APB  = 14'b00100000000000,
        S_APC  = 14'b01000000000000,
        S_APD  = 14'b10000000000000
    } t_state;

    localparam logic [OFF_W-1:0] HDR = OFF_W'(HEADER_BYTES);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_b, n_b, r_steps, n_steps, r_l, n_l, r_new, n_new;
    logic [CNT_W-1:0]  r_plast, n_plast, r_first, n_first, r_last, n_last;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [1:0]        r_cmd, n_cmd;
    logic [19:0]       r_req, n_req, r_faddr, n_faddr;
    logic [OFF_W-1:0]  r_s, n_s, r_z, n_z, r_n, n_n, r_pay, n_pay, r_cut, n_cut;
    logic [OFF_W-1:0]  r_heap_top, n_heap_top;
    logic              r_ok, n_ok;
    logic [HEAP_W-1:0] r_hb;
    logic              r_done, n_done;
    logic [1:0]        r_status, n_status;
    logic [19:0]       r_addr, n_addr;

    logic              blk_we, lnk_we;
    logic [IDX_W-1:0]  blk_waddr, lnk_waddr, raddr;
    t_blk              blk_wdata, blk_rdata;
    logic [CNT_W-1:0]  lnk_wdata, lnk_rdata;

    logic [OFF_W-1:0]  req_x, faddr_x, hb_x, pay_addr;
    logic [CNT_W-1:0]  count_inc;
    logic              cfg_wr;

    ffba_ram #(.WIDTH(BLK_W), .DEPTH(MAX_BLOCKS)) u_blk_ram (
        .i_clk   (i_clk),
        .i_we    (blk_we),
        .i_waddr (blk_waddr),
        .i_wdata (blk_wdata),
        .i_raddr (raddr),
        .o_rdata (blk_rdata)
    );

    ffba_ram #(.WIDTH(CNT_W), .DEPTH(MAX_BLOCKS)) u_lnk_ram (
        .i_clk   (i_clk),
        .i_we    (lnk_we),
        .i_waddr (lnk_waddr),
        .i_wdata (lnk_wdata),
        .i_raddr (raddr),
        .o_rdata (lnk_rdata)
    );

    assign req_x     = OFF_W'(r_req);
    assign faddr_x   = OFF_W'(r_faddr);
    assign hb_x      = OFF_W'(r_hb);
    assign pay_addr  = r_s + HDR;
    assign count_inc = r_count + CNT_W'(1);
    assign raddr     = (r_state == S_NXT) ? r_l[IDX_W-1:0] : r_b[IDX_W-1:0];

    // config port
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == 3'd0);
    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? 32'(r_hb) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hb <= HEAP_W'(HEAP_RESET);
        end else if (cfg_wr) begin
            r_hb <= pwdata[HEAP_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;  n_b = r_b;  n_steps = r_steps;  n_l = r_l;
        n_new = r_new;  n_plast = r_plast;  n_first = r_first;  n_last = r_last;
        n_count = r_count;  n_cmd = r_cmd;  n_req = r_req;  n_faddr = r_faddr;
        n_s = r_s;  n_z = r_z;  n_n = r_n;  n_pay = r_pay;  n_cut = r_cut;
        n_heap_top = r_heap_top;  n_ok = r_ok;
        n_done = 1'b0;  n_status = r_status;  n_addr = r_addr;
        blk_we = 1'b0;  blk_waddr = r_b[IDX_W-1:0];
        blk_wdata = '{offset: r_s, size: r_z, is_free: 1'b0};
        lnk_we = 1'b0;  lnk_waddr = r_b[IDX_W-1:0];  lnk_wdata = r_new;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd = i_cmd;  n_req = i_request_bytes;  n_faddr = i_free_address;
                    n_b = r_first;  n_steps = '0;
                    if (i_cmd == CMD_ALLOC || i_cmd == CMD_FREE) begin
                        n_state = S_WALK;
                    end else begin
                        if (i_cmd == CMD_RESET) begin
                            n_first = NO_BLOCK;  n_last = NO_BLOCK;
                            n_count = '0;  n_heap_top = '0;
                        end
                        n_done = 1'b1;  n_status = ST_OK;  n_addr = '0;
                    end
                end
            end
            S_WALK: begin
                if (r_b < r_count && r_steps < CNT_W'(MAX_BLOCKS)) begin
                    n_state = S_CHK;
                end else if (r_cmd == CMD_ALLOC) begin
                    n_state = S_APA;
                end else begin
                    n_state = S_IDLE;
                    n_done = 1'b1;  n_status = ST_NOT_FOUND;  n_addr = '0;
                end
            end
            S_CHK: begin
                n_s = blk_rdata.offset;  n_z = blk_rdata.size;  n_l = lnk_rdata;
                n_n = blk_rdata.offset + HDR + blk_rdata.size;
                if (r_cmd == CMD_FREE) begin
                    if (blk_rdata.offset + HDR == faddr_x) begin
                        blk_we = 1'b1;
                        blk_wdata = '{offset: blk_rdata.offset, size: blk_rdata.size,
                                      is_free: 1'b1};
                        n_state = S_IDLE;
                        n_done = 1'b1;  n_status = ST_OK;  n_addr = '0;
                    end else begin
                        n_b = lnk_rdata;  n_steps = r_steps + CNT_W'(1);
                        n_state = S_WALK;
                    end
                end else if (blk_rdata.is_free && blk_rdata.size >= req_x) begin
                    n_state = (lnk_rdata < r_count) ? S_NXT : S_SPA;
                end else begin
                    n_b = lnk_rdata;  n_steps = r_steps + CNT_W'(1);
                    n_state = S_WALK;
                end
            end
            S_NXT: begin
                n_state = S_NXG;
            end
            S_NXG: begin
                n_n = blk_rdata.offset;
                n_state = S_SPA;
            end
            S_SPA: begin
                n_pay = r_s + HDR + req_x;
                n_ok = (r_n >= r_s + HDR);
                n_state = S_SPB;
            end
            S_SPB: begin
                n_ok = r_ok && (r_n >= r_pay + OFF_W'(SPLIT_MIN));
                n_cut = round_up(r_pay);
                n_state = S_SPC;
            end
            S_SPC: begin
                n_ok = r_ok && (r_cut + HDR <= r_n) && (r_count < CNT_W'(MAX_BLOCKS));
                n_state = n_ok ? S_WRN : S_WRB;
            end
            S_WRN: begin
                blk_we = 1'b1;  blk_waddr = r_count[IDX_W-1:0];
                blk_wdata = '{offset: r_cut, size: r_n - r_cut - HDR, is_free: 1'b1};
                lnk_we = 1'b1;  lnk_waddr = r_count[IDX_W-1:0];  lnk_wdata = r_l;
                n_new = r_count;  n_count = count_inc;
                if (r_last == r_b) begin
                    n_last = r_count;
                end
                n_state = S_WRB;
            end
            S_WRB: begin
                blk_we = 1'b1;
                blk_wdata = '{offset: r_s, size: r_ok ? (r_cut - r_s - HDR) : r_z,
                              is_free: 1'b0};
                lnk_we = r_ok;
                n_state = S_IDLE;
                n_done = 1'b1;  n_status = ST_OK;  n_addr = pay_addr[ADDR_BITS-1:0];
            end
            S_APA: begin
                n_s = round_up(r_heap_top);
                n_state = S_APB;
            end
            S_APB: begin
                n_pay = r_s + HDR + req_x;
                n_ok = (r_s <= hb_x);
                n_state = S_APC;
            end
            S_APC: begin
                if (!r_ok || r_pay > hb_x) begin
                    n_state = S_IDLE;
                    n_done = 1'b1;  n_status = ST_NO_SPACE;  n_addr = '0;
                end else if (r_count >= CNT_W'(MAX_BLOCKS)) begin
                    n_state = S_IDLE;
                    n_done = 1'b1;  n_status = ST_TABLE_FULL;  n_addr = '0;
                end else begin
                    n_cut = round_up(r_pay);
                    n_state = S_APD;
                end
            end
            S_APD: begin
                blk_we = 1'b1;  blk_waddr = r_count[IDX_W-1:0];
                blk_wdata = '{offset: r_s, size: r_cut - r_s - HDR, is_free: 1'b0};
                lnk_we = 1'b1;  lnk_waddr = r_count[IDX_W-1:0];  lnk_wdata = NO_BLOCK;
                n_new = r_count;  n_plast = r_last;  n_count = count_inc;
                n_heap_top = r_cut;
                if (r_first >= count_inc) begin
                    n_first = r_count;
                end
                n_last = r_count;
                if (r_last < count_inc) begin
                    n_b = r_last;
                    n_state = S_WRB;
                    n_ok = 1'b0;
                end else begin
                    n_state = S_IDLE;
                end
                n_done = !(r_last < count_inc);
                n_status = ST_OK;  n_addr = pay_addr[ADDR_BITS-1:0];
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // link the previous last block to the appended one
        if (r_state == S_WRB && r_cmd == CMD_ALLOC && r_plast == r_b && !r_ok
                && r_new == r_last && r_heap_top == r_cut && r_b != r_last) begin
            blk_we = 1'b0;
            lnk_we = 1'b1;
            lnk_waddr = r_b[IDX_W-1:0];
            lnk_wdata = r_new;
            n_addr = pay_addr[ADDR_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;  r_first <= NO_BLOCK;  r_last <= NO_BLOCK;
            r_count <= '0;  r_heap_top <= '0;  r_done <= 1'b0;
            r_status <= ST_OK;  r_addr <= '0;
        end else begin
            r_state <= n_state;  r_first <= n_first;  r_last <= n_last;
            r_count <= n_count;  r_heap_top <= n_heap_top;  r_done <= n_done;
            r_status <= n_status;  r_addr <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b <= n_b;  r_steps <= n_steps;  r_l <= n_l;  r_new <= n_new;
        r_plast <= n_plast;  r_cmd <= n_cmd;  r_req <= n_req;  r_faddr <= n_faddr;
        r_s <= n_s;  r_z <= n_z;  r_n <= n_n;  r_pay <= n_pay;  r_cut <= n_cut;
        r_ok <= n_ok;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_payload_address = r_addr;

`ifndef ASSERT_OFF
    a_done_on_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done) else $error("busy dropped without a result");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result strobe while busy");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BLOCKS)) else $error("block count past table size");
    a_fail_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> o_payload_address == '0)
        else $error("failed command returned an address");
`endif

endmodule

// ===== src/ffba_ram.sv =====
// ffba_ram: generic single-write, single-read memory with registered read
// no dependencies
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
